### rtl/core/tea_pkg.sv
// Shared definitions for the terminal escape to ANSI translator.
// Holds character codes, widths, and the command record passed from parser to expander.
// No dependencies.
package tea_pkg;

    // Parameter accumulator width; skip counter holds label plus string length
    localparam int PARAM_W = 16;
    localparam int SKIP_W  = PARAM_W + 1;

    // Command queue depth between parser and expander
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4a;
    localparam logic [7:0] CH_K     = 8'h4b;
    localparam logic [7:0] CH_L     = 8'h4c;
    localparam logic [7:0] CH_Z     = 8'h5a;
    localparam logic [7:0] CH_LBR   = 8'h5b;
    localparam logic [7:0] CH_US    = 8'h5f;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_H  = 8'h68;
    localparam logic [7:0] CH_LC_L  = 8'h6c;
    localparam logic [7:0] CH_LC_M  = 8'h6d;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // One queued command: a list of one to three literal bytes, optionally a
    // delay marker, optionally followed by the SGR attribute tail.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            delay;
        logic            sgr;
        logic [3:0]      attr;
    } tea_cmd_t;

endpackage

### rtl/core/tea_front.sv
// Parser front end: accepts input bytes, tracks escape parsing state and
// pushes one command per byte that yields output. Depends on tea_pkg.
module tea_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    input  logic              cfg_valid,
    input  logic              cfg_ansi_enable,
    input  logic              q_full,
    output logic              q_push,
    output tea_pkg::tea_cmd_t q_cmd
);
    import tea_pkg::*;

    typedef enum logic [6:0] {
        MODE_TEXT  = 7'b0000001,
        MODE_ESC   = 7'b0000010,
        MODE_AMP   = 7'b0000100,
        MODE_PARAM = 7'b0001000,
        MODE_SKIP  = 7'b0010000,
        MODE_US    = 7'b0100000,
        MODE_USCR  = 7'b1000000
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [7:0]         group_reg, group_next;
    logic [PARAM_W-1:0] param_reg, param_next;
    logic               neg_reg, neg_next;
    logic [PARAM_W-1:0] label_reg, label_next;
    logic [PARAM_W-1:0] string_reg, string_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic               enable_reg;

    logic               accept;
    logic               emit;
    tea_cmd_t           cmd;
    logic [7:0]         c;
    mode_t              t_mode;
    logic               t_emit;
    logic               is_digit;
    logic               is_upper;
    logic               is_cursor;
    logic [PARAM_W+3:0] acc;
    logic [PARAM_W-1:0] len_val;

    assign c       = s_in_byte;
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && emit;
    assign q_cmd   = cmd;

    // Classify the byte as plain text
    always_comb begin
        if (c == CH_ESC) begin
            t_mode = MODE_ESC;
        end else if (c == CH_US) begin
            t_mode = MODE_US;
        end else begin
            t_mode = MODE_TEXT;
        end
        t_emit = (c != CH_ESC) && (c != CH_US) && (c != CH_NUL) && (c != CH_DEL);
    end

    assign is_digit  = (c >= CH_0) && (c <= CH_9);
    assign is_upper  = (c >= CH_A) && (c <= CH_Z);
    assign is_cursor = (c == CH_A) || (c == CH_B) || (c == CH_C) || (c == CH_D)
                    || (c == CH_H) || (c == CH_J) || (c == CH_K);

    // Decimal accumulate: param * 10 + digit, saturate past the all-ones value
    assign acc = ({4'b0, param_reg} << 3) + ({4'b0, param_reg} << 1)
               + {{PARAM_W{1'b0}}, c[3:0]};
    assign len_val = neg_reg ? '0 : param_reg;

    // Next parser state and command for this byte
    always_comb begin
        mode_next   = mode_reg;
        group_next  = group_reg;
        param_next  = param_reg;
        neg_next    = neg_reg;
        label_next  = label_reg;
        string_next = string_reg;
        skip_next   = skip_reg;
        cmd         = '0;
        emit        = 1'b0;
        unique case (mode_reg)
            MODE_TEXT: begin
                mode_next = t_mode;
                if (t_emit) begin
                    cmd.bytes[0] = c;
                    cmd.count    = 2'd1;
                    emit         = 1'b1;
                end
            end
            MODE_US: begin
                if (c == CH_CR) begin
                    mode_next = MODE_USCR;
                end else if (c == CH_US) begin
                    cmd.bytes[0] = CH_US;
                    cmd.count    = 2'd1;
                    emit         = 1'b1;
                end else begin
                    mode_next    = t_mode;
                    cmd.bytes[0] = CH_US;
                    cmd.bytes[1] = c;
                    cmd.count    = t_emit ? 2'd2 : 2'd1;
                    emit         = 1'b1;
                end
            end
            MODE_USCR: begin
                mode_next = MODE_TEXT;
                if (c != CH_LF) begin
                    mode_next    = t_mode;
                    cmd.bytes[0] = CH_US;
                    cmd.bytes[1] = CH_CR;
                    cmd.bytes[2] = c;
                    cmd.count    = t_emit ? 2'd3 : 2'd2;
                    emit         = 1'b1;
                end
            end
            MODE_ESC: begin
                if (c == CH_AMP) begin
                    mode_next = MODE_AMP;
                end else begin
                    mode_next = MODE_TEXT;
                    if (enable_reg) begin
                        if (is_cursor || c == CH_LC_H) begin
                            cmd.bytes[0] = CH_ESC;
                            cmd.bytes[1] = CH_LBR;
                            cmd.bytes[2] = is_cursor ? c : CH_H;
                            cmd.count    = 2'd3;
                            emit         = 1'b1;
                        end else if (c == CH_AT) begin
                            cmd.bytes[0] = CH_NUL;
                            cmd.count    = 2'd1;
                            cmd.delay    = 1'b1;
                            emit         = 1'b1;
                        end
                    end
                end
            end
            MODE_AMP: begin
                group_next  = c;
                param_next  = '0;
                neg_next    = 1'b0;
                label_next  = '0;
                string_next = '0;
                mode_next   = MODE_PARAM;
            end
            MODE_PARAM: begin
                if (is_digit) begin
                    if (acc > {4'b0, {PARAM_W{1'b1}}}) begin
                        param_next = {PARAM_W{1'b1}};
                    end else begin
                        param_next = acc[PARAM_W-1:0];
                    end
                end else if (c == CH_MINUS) begin
                    neg_next = 1'b1;
                end else if (c == CH_PLUS || c == CH_SPACE) begin
                    neg_next = neg_reg;
                end else if (group_reg == CH_LC_D) begin
                    mode_next = MODE_TEXT;
                    if (enable_reg) begin
                        cmd.bytes[0] = CH_ESC;
                        cmd.bytes[1] = CH_LBR;
                        cmd.bytes[2] = CH_0;
                        cmd.count    = 2'd3;
                        cmd.sgr      = 1'b1;
                        cmd.attr     = c[3:0];
                        emit         = 1'b1;
                    end
                end else begin
                    if (group_reg == CH_LC_F) begin
                        if (c == CH_LC_D || c == CH_D) begin
                            label_next = len_val;
                        end
                        if (c == CH_LC_L || c == CH_L) begin
                            string_next = len_val;
                        end
                    end
                    param_next = '0;
                    neg_next   = 1'b0;
                    if (is_upper) begin
                        if (group_reg == CH_LC_F) begin
                            skip_next = {1'b0, label_next} + {1'b0, string_next};
                        end else begin
                            skip_next = '0;
                        end
                        mode_next = (skip_next != '0) ? MODE_SKIP : MODE_TEXT;
                    end
                end
            end
            MODE_SKIP: begin
                if (skip_reg <= SKIP_W'(1)) begin
                    skip_next = '0;
                    mode_next = MODE_TEXT;
                end else begin
                    skip_next = skip_reg - SKIP_W'(1);
                end
            end
            default: begin
                mode_next = MODE_TEXT;
            end
        endcase
    end

    // Advance parser state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_TEXT;
            group_reg  <= '0;
            param_reg  <= '0;
            neg_reg    <= 1'b0;
            label_reg  <= '0;
            string_reg <= '0;
            skip_reg   <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            group_reg  <= group_next;
            param_reg  <= param_next;
            neg_reg    <= neg_next;
            label_reg  <= label_next;
            string_reg <= string_next;
            skip_reg   <= skip_next;
        end
    end

    // Hold the escape output enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            enable_reg <= cfg_ansi_enable;
        end
    end

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SKIP |-> skip_reg != '0)
        else $error("skip mode entered with zero count");

    a_cmd_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_cmd.count != 2'd0)
        else $error("command pushed with empty byte list");

    a_sgr_no_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_cmd.sgr |-> !q_cmd.delay && enable_reg)
        else $error("malformed attribute command");

endmodule

### rtl/core/tea_cmd_queue.sv
// Short command queue between the parser and the expander.
// Depends on tea_pkg for the command record and depth.
module tea_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tea_pkg::tea_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tea_pkg::tea_cmd_t head_cmd
);
    import tea_pkg::*;

    tea_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty command queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule

### rtl/core/tea_back.sv
// Expander back end: turns the head command into result beats, one per cycle
// unless the output stalls, through a registered output stage. Depends on tea_pkg.
module tea_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  tea_pkg::tea_cmd_t head_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_is_delay,
    output logic              m_last
);
    import tea_pkg::*;

    typedef enum logic [3:0] {
        PH_LIST  = 4'b0001,
        PH_SEMI  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_MARK  = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] pos_reg, pos_next;
    logic [3:0] mask_reg, mask_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       delay_reg;
    logic       last_reg;

    logic       advance;
    logic [7:0] item_byte;
    logic       item_delay;
    logic       item_last;

    assign advance    = head_valid && (!valid_reg || m_ready);
    assign pop        = advance && item_last;
    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_is_delay = delay_reg;
    assign m_last     = last_reg;

    // Produce the current beat of the head command
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        mask_next  = mask_reg;
        item_byte  = CH_NUL;
        item_delay = 1'b0;
        item_last  = 1'b0;
        unique case (phase_reg)
            PH_LIST: begin
                item_byte  = head_cmd.bytes[pos_reg];
                item_delay = head_cmd.delay;
                if (pos_reg != head_cmd.count - 2'd1) begin
                    pos_next = pos_reg + 2'd1;
                end else if (!head_cmd.sgr) begin
                    item_last = 1'b1;
                end else if (head_cmd.attr != 4'd0) begin
                    phase_next = PH_SEMI;
                    mask_next  = head_cmd.attr;
                end else begin
                    phase_next = PH_MARK;
                end
            end
            PH_SEMI: begin
                item_byte  = CH_SEMI;
                phase_next = PH_DIGIT;
            end
            PH_DIGIT: begin
                if (mask_reg[0]) begin
                    item_byte = CH_5;
                end else if (mask_reg[1]) begin
                    item_byte = CH_7;
                end else if (mask_reg[2]) begin
                    item_byte = CH_4;
                end else begin
                    item_byte = CH_2;
                end
                mask_next  = mask_reg & (mask_reg - 4'd1);
                phase_next = (mask_next != 4'd0) ? PH_SEMI : PH_MARK;
            end
            PH_MARK: begin
                item_byte = CH_LC_M;
                item_last = 1'b1;
            end
            default: begin
                phase_next = PH_LIST;
            end
        endcase
        if (item_last) begin
            phase_next = PH_LIST;
            pos_next   = 2'd0;
        end
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LIST;
            pos_reg   <= 2'd0;
        end else if (advance) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mask_reg <= mask_next;
        end
    end

    // Output stage: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg  <= item_byte;
            delay_reg <= item_delay;
            last_reg  <= item_last;
        end
    end

    a_mid_cmd_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_LIST || pos_reg != 2'd0 |-> head_valid)
        else $error("expander mid-command without a head entry");

    a_digit_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DIGIT |-> mask_reg != 4'd0)
        else $error("attribute digit with empty mask");

    a_delay_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && delay_reg |-> byte_reg == CH_NUL && last_reg)
        else $error("delay marker beat malformed");

endmodule

### rtl/core/terminal_escape_to_ansi_translator.sv
// Terminal escape to ANSI translator, top level.
// Instantiates tea_front, tea_cmd_queue and tea_back; uses tea_pkg.
//
// Takes one byte of a program's output per beat on s_* and delivers display
// bytes on m_*, with m_last marking the final result of each input byte
// (bytes that give no result produce no beat). Input is taken every cycle
// while the four-entry command queue has room; the expander sends out every
// result of a command before popping it, so plain text runs at one byte per
// cycle while the output does not stall, and a byte that expands to N results
// (up to 12 for an attribute string) holds the expander until all are out,
// with input stalling only once the queue fills. ansi_enable is written over
// cfg_valid/cfg_ready (always ready) and should change only while the block is idle.
module terminal_escape_to_ansi_translator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_delay,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_ansi_enable
);
    import tea_pkg::*;

    logic     q_full;
    logic     q_push;
    tea_cmd_t q_cmd;
    logic     q_pop;
    logic     q_head_valid;
    tea_cmd_t q_head;

    assign cfg_ready = 1'b1;

    tea_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ansi_enable (cfg_ansi_enable),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_cmd)
    );

    tea_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    tea_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_is_delay (m_is_delay),
        .m_last     (m_last)
    );

endmodule

### bench/ansi_stream_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the terminal escape to ANSI translator: predicts display beats
// from accepted input bytes and compares them with the m_* channel.
// Depends on tea_pkg for widths and character codes.
module ansi_stream_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_is_delay,
    input  logic       m_last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_ansi_enable,
    output int         fail_count,
    output int         display_backlog
);
    import tea_pkg::*;

    typedef enum logic [6:0] {
        PM_TEXT  = 7'b0000001,
        PM_ESC   = 7'b0000010,
        PM_AMP   = 7'b0000100,
        PM_PARAM = 7'b0001000,
        PM_SKIP  = 7'b0010000,
        PM_US    = 7'b0100000,
        PM_USCR  = 7'b1000000
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_delay;
        logic       last;
    } display_beat_t;

    // Shadow copy of the parser state and the enable register
    parse_mode_t         mode_q;
    logic [7:0]          group_q;
    logic [PARAM_W-1:0]  param_q;
    logic                neg_q;
    logic [PARAM_W-1:0]  label_len_q;
    logic [PARAM_W-1:0]  string_len_q;
    logic [SKIP_W-1:0]   skip_q;
    logic                ansi_on;

    display_beat_t       step_beats[$];
    display_beat_t       pending_display[$];

    function automatic void emit_byte(input logic [7:0] value, input logic delay);
        display_beat_t beat;
        beat.out_byte = value;
        beat.is_delay = delay;
        beat.last     = 1'b0;
        step_beats.push_back(beat);
    endfunction

    // Escape output is gated by the enable register; plain text is not
    function automatic void emit_escape(input logic [7:0] value);
        if (ansi_on) emit_byte(value, 1'b0);
    endfunction

    function automatic void emit_sgr(input logic [3:0] attr);
        emit_escape(CH_ESC);
        emit_escape(CH_LBR);
        emit_escape(CH_0);
        if (attr[0]) begin
            emit_escape(CH_SEMI);
            emit_escape(CH_5);
        end
        if (attr[1]) begin
            emit_escape(CH_SEMI);
            emit_escape(CH_7);
        end
        if (attr[2]) begin
            emit_escape(CH_SEMI);
            emit_escape(CH_4);
        end
        if (attr[3]) begin
            emit_escape(CH_SEMI);
            emit_escape(CH_2);
        end
        emit_escape(CH_LC_M);
    endfunction

    function automatic void cursor_code(input logic [7:0] c);
        case (c)
            CH_A, CH_B, CH_C, CH_D, CH_H, CH_J, CH_K: begin
                emit_escape(CH_ESC);
                emit_escape(CH_LBR);
                emit_escape(c);
            end
            CH_LC_H: begin
                emit_escape(CH_ESC);
                emit_escape(CH_LBR);
                emit_escape(CH_H);
            end
            CH_AT: begin
                if (ansi_on) emit_byte(CH_NUL, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        if (c == CH_ESC) mode_q = PM_ESC;
        else if (c == CH_US) mode_q = PM_US;
        else if (c != CH_NUL && c != CH_DEL) emit_byte(c, 1'b0);
    endfunction

    // Parameter bytes of an ampersand group
    function automatic void param_char(input logic [7:0] c);
        longint unsigned    limit;
        longint unsigned    digit;
        logic [PARAM_W-1:0] len;
        limit = (64'd1 << PARAM_W) - 64'd1;
        if (c >= CH_0 && c <= CH_9) begin
            digit = 64'(c - CH_0);
            // saturate the accumulator instead of wrapping
            if (64'(param_q) > (limit - digit) / 64'd10) param_q = '1;
            else param_q = PARAM_W'(64'(param_q) * 64'd10 + digit);
        end else if (c == CH_MINUS) begin
            neg_q = 1'b1;
        end else if (c == CH_PLUS || c == CH_SPACE) begin
        end else if (group_q == CH_LC_D) begin
            emit_sgr(c[3:0]);
            mode_q = PM_TEXT;
        end else begin
            if (group_q == CH_LC_F) begin
                len = neg_q ? '0 : param_q;
                if (c == CH_LC_D || c == CH_D) label_len_q = len;
                if (c == CH_LC_L || c == CH_L) string_len_q = len;
            end
            param_q = '0;
            neg_q   = 1'b0;
            if (c >= CH_A && c <= CH_Z) begin
                if (group_q == CH_LC_F) skip_q = {1'b0, label_len_q} + {1'b0, string_len_q};
                else skip_q = '0;
                mode_q = (skip_q != '0) ? PM_SKIP : PM_TEXT;
            end
        end
    endfunction

    // Work out the display beats of one input byte and queue them
    function automatic void translate_byte(input logic [7:0] c);
        step_beats.delete();
        unique case (mode_q)
            PM_US: begin
                if (c == CH_CR) begin
                    mode_q = PM_USCR;
                end else if (c == CH_US) begin
                    emit_byte(CH_US, 1'b0);
                end else begin
                    emit_byte(CH_US, 1'b0);
                    mode_q = PM_TEXT;
                    plain_byte(c);
                end
            end
            PM_USCR: begin
                mode_q = PM_TEXT;
                if (c != CH_LF) begin
                    emit_byte(CH_US, 1'b0);
                    emit_byte(CH_CR, 1'b0);
                    plain_byte(c);
                end
            end
            PM_ESC: begin
                if (c == CH_AMP) begin
                    mode_q = PM_AMP;
                end else begin
                    cursor_code(c);
                    mode_q = PM_TEXT;
                end
            end
            PM_AMP: begin
                group_q      = c;
                param_q      = '0;
                neg_q        = 1'b0;
                label_len_q  = '0;
                string_len_q = '0;
                mode_q       = PM_PARAM;
            end
            PM_PARAM: begin
                param_char(c);
            end
            PM_SKIP: begin
                if (skip_q <= SKIP_W'(1)) begin
                    skip_q = '0;
                    mode_q = PM_TEXT;
                end else begin
                    skip_q = skip_q - SKIP_W'(1);
                end
            end
            default: begin
                mode_q = PM_TEXT;
                plain_byte(c);
            end
        endcase
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i]) pending_display.push_back(step_beats[i]);
    endfunction

    // Watch the channels: push predictions before popping, so a same-edge
    // result still finds its expectation in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q       = PM_TEXT;
            group_q      = '0;
            param_q      = '0;
            neg_q        = 1'b0;
            label_len_q  = '0;
            string_len_q = '0;
            skip_q       = '0;
            ansi_on      = 1'b1;
            fail_count   = 0;
            pending_display.delete();
        end else begin
            if (cfg_valid && cfg_ready) ansi_on = cfg_ansi_enable;
            if (s_valid && s_ready) translate_byte(s_in_byte);
            if (m_valid && m_ready) begin
                if (pending_display.size() == 0) begin
                    $display("%0t: unexpected display beat out_byte=%h is_delay=%b last=%b",
                             $time, m_out_byte, m_is_delay, m_last);
                    fail_count++;
                end else begin
                    if (m_out_byte !== pending_display[0].out_byte) begin
                        $display("%0t: out_byte expected %h got %h",
                                 $time, pending_display[0].out_byte, m_out_byte);
                        fail_count++;
                    end
                    if (m_is_delay !== pending_display[0].is_delay) begin
                        $display("%0t: is_delay expected %b got %b",
                                 $time, pending_display[0].is_delay, m_is_delay);
                        fail_count++;
                    end
                    if (m_last !== pending_display[0].last) begin
                        $display("%0t: last expected %b got %b",
                                 $time, pending_display[0].last, m_last);
                        fail_count++;
                    end
                    void'(pending_display.pop_front());
                end
            end
        end
        display_backlog = pending_display.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the translator testbench: clock, reset, byte stimulus, enable writes
// and the verdict. Depends on tea_pkg, ansi_stream_checker and the translator.
module tb_top;
    import tea_pkg::*;

    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_ITEMS   = 5;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic [7:0] s_in_byte       = 8'h00;
    logic       m_ready         = 1'b0;
    logic       cfg_valid       = 1'b0;
    logic       cfg_ansi_enable = 1'b1;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_is_delay;
    logic       m_last;
    logic       cfg_ready;
    int         fail_count;
    int         display_backlog;

    int         burst_left  = 0;
    int         items_sent  = 0;
    int         stall_left  = 0;
    int         stall_mode  = 0;
    int         cycle_count = 0;

    always #5 aclk = ~aclk;

    terminal_escape_to_ansi_translator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_delay      (m_is_delay),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_ansi_enable (cfg_ansi_enable)
    );

    ansi_stream_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_delay      (m_is_delay),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_ansi_enable (cfg_ansi_enable),
        .fail_count      (fail_count),
        .display_backlog (display_backlog)
    );

    // Stall the display side: switch between stall patterns every so often
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= stall_left[2];
        endcase
    end

    // Send one byte beat; open a new burst after a random gap when one runs out
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid   <= 1'b1;
        s_in_byte <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_chars(input string text);
        for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    endtask

    task automatic send_amp(input string body);
        send_byte(CH_ESC);
        send_byte(CH_AMP);
        send_chars(body);
    endtask

    task automatic send_filler(input int count);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold until every display beat is out and the block settles
    task automatic hold_until_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        wait (display_backlog == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_ansi_enable(input logic value);
        cfg_valid       <= 1'b1;
        cfg_ansi_enable <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random sequence: mostly well-formed escapes with random content
    task automatic random_sequence();
        int         pick;
        int         sub;
        string      cursor_set;
        string      body;
        logic [7:0] tail;
        cursor_set = "ABCDHJKh@";
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 30) begin
            send_byte(CH_US);
            sub = $urandom_range(0, 3);
            if (sub == 0) begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else if (sub == 1) begin
                send_byte(CH_CR);
                send_byte(8'($urandom_range(0, 255)));
            end else if (sub == 2) begin
                send_byte(CH_US);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end else if (pick < 50) begin
            send_byte(CH_ESC);
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
            else send_byte(cursor_set[$urandom_range(0, cursor_set.len() - 1)]);
        end else if (pick < 70) begin
            body = $sformatf("d%s%0d", ($urandom_range(0, 1) != 0) ? "- " : "+",
                             $urandom_range(0, 99999));
            do tail = 8'($urandom_range(0, 255));
            while ((tail >= CH_0 && tail <= CH_9) || tail == CH_MINUS ||
                   tail == CH_PLUS || tail == CH_SPACE);
            send_amp(body);
            send_byte(tail);
        end else if (pick < 85) begin
            body = $sformatf("f%s%0dd %0d%s", ($urandom_range(0, 1) != 0) ? "-" : "+",
                             $urandom_range(0, 3), $urandom_range(0, 3),
                             ($urandom_range(0, 1) != 0) ? "l" : "L");
            send_amp(body);
            send_byte(8'(CH_A + $urandom_range(0, 25)));
            send_filler($urandom_range(0, 6));
        end else begin
            send_byte(CH_ESC);
            send_byte(CH_AMP);
            send_byte(8'($urandom_range(0, 255)));
            send_chars($sformatf("%0dq%0d", $urandom_range(0, 999), $urandom_range(0, 99)));
            send_byte(8'(CH_A + $urandom_range(0, 25)));
        end
    endtask

    task automatic random_phase(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) random_sequence();
    endtask

    // Bound the run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        string letters;
        letters = "BCDHJKh@z";
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_ansi_enable(1'b1);

        // Directed: text extremes and drops, underscore forms, cursor letters
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CH_DEL);
        send_chars("a");
        send_byte(CH_US);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_US);
        send_byte(CH_US);
        send_chars("x");
        send_byte(CH_US);
        send_byte(CH_CR);
        send_chars("y");
        send_byte(CH_US);
        send_byte(CH_ESC);
        send_chars("A");
        for (int i = 0; i < letters.len(); i++) begin
            send_byte(CH_ESC);
            send_byte(letters[i]);
        end

        // Directed: attribute strings, softkey skips, other groups
        send_amp("dO");
        send_amp("d@");
        send_amp("d-+ 7");
        send_byte(8'hfa);
        send_amp("f2d3LA");
        send_filler(5);
        send_chars("k");
        send_amp("f-4d+ 1lZ");
        send_filler(1);
        send_chars("t");
        send_amp("x12q34R");
        send_chars("u");

        // Saturate the label length, then redefine it and set the string length before the skip
        send_amp("f99999d3d2LB");
        send_filler(5);
        send_chars("v");
        hold_until_drained();

        // Escape output off: parsing goes on, only text comes out
        write_ansi_enable(1'b0);
        send_byte(CH_ESC);
        send_chars("A");
        send_byte(CH_ESC);
        send_byte(CH_AT);
        send_amp("dO");
        send_chars("w");
        random_phase(PHASE_ITEMS);
        hold_until_drained();

        // Escape output back on, with one full drain in the middle
        write_ansi_enable(1'b1);
        random_phase(PHASE_ITEMS);
        hold_until_drained();
        random_phase(PHASE_ITEMS);
        hold_until_drained();

        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tea_pkg.sv
rtl/core/tea_front.sv
rtl/core/tea_cmd_queue.sv
rtl/core/tea_back.sv
rtl/core/terminal_escape_to_ansi_translator.sv
bench/ansi_stream_checker.sv
bench/tb_top.sv
